FILE: src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and defaults of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int BLOCK_BYTES_DEF  = 64;
  localparam int MAX_BLOCKS_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int ADDR_W    = 64;
  localparam int SIZE_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = CFG_IDX_W'(1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFIT    = 2'd1,
    STAT_NOTALLOC = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ALIGN,
    S_CLEAR,
    S_A_RD,
    S_A_EV,
    S_WR,
    S_F_SCAN,
    S_F_RD,
    S_F_EV
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    setup_init;
    logic    align;
    logic    clear_step;
    logic    req_init;
    logic    a_eval;
    logic    a_wr_init;
    logic    f_step;
    logic    f_wr_init;
    logic    wr_step;
    logic    post;
    status_t post_st;
  } ffba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic scan_end;
    logic fit;
    logic match;
    logic start_bit;
    logic wr_last;
    logic bad_addr;
  } ffba_sts_t;

endpackage

FILE: src/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: heap setup, first-fit scan, free lookup and block map writes.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_cmd,
  input  logic                cfg_we,
  input  ffba_pkg::ffba_sts_t sts,
  output ffba_pkg::ffba_cmd_t cmd,
  output logic                busy
);
  import ffba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (in_cmd == CMD_FREE) ? S_F_SCAN : S_A_RD;
      end
      S_INIT:   state_nxt = S_ALIGN;
      S_ALIGN:  state_nxt = S_CLEAR;
      S_CLEAR:  if (sts.clear_done) state_nxt = S_IDLE;
      S_A_RD:   state_nxt = sts.scan_end ? S_IDLE : S_A_EV;
      S_A_EV:   state_nxt = sts.fit ? S_WR : S_A_RD;
      S_WR:     if (sts.wr_last) state_nxt = S_IDLE;
      S_F_SCAN: begin
        if (sts.bad_addr || sts.scan_end) state_nxt = S_IDLE;
        else if (sts.match)               state_nxt = S_F_RD;
      end
      S_F_RD:   state_nxt = S_F_EV;
      S_F_EV:   state_nxt = sts.start_bit ? S_WR : S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
    // a register write restarts heap setup
    if (cfg_we) state_nxt = S_INIT;
  end

  always_comb begin
    cmd         = '0;
    cmd.post_st = STAT_OK;
    busy        = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:  cmd.req_init = start;
      S_INIT:  cmd.setup_init = 1'b1;
      S_ALIGN: cmd.align = 1'b1;
      S_CLEAR: cmd.clear_step = 1'b1;
      S_A_RD: begin
        if (sts.scan_end) begin
          cmd.post    = 1'b1;
          cmd.post_st = STAT_NOFIT;
        end
      end
      S_A_EV: begin
        cmd.a_eval    = 1'b1;
        cmd.a_wr_init = sts.fit;
      end
      S_WR: begin
        cmd.wr_step = 1'b1;
        cmd.post    = sts.wr_last;
      end
      S_F_SCAN: begin
        if (sts.bad_addr || sts.scan_end) begin
          cmd.post    = 1'b1;
          cmd.post_st = STAT_NOTALLOC;
        end else if (!sts.match) begin
          cmd.f_step = 1'b1;
        end
      end
      S_F_RD: ;
      S_F_EV: begin
        if (sts.start_bit) begin
          cmd.f_wr_init = 1'b1;
        end else begin
          cmd.post    = 1'b1;
          cmd.post_st = STAT_NOTALLOC;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp
// Heap registers, block map memory, scan counters and result register.
// ----------------------------------------------------------------------------
module ffba_dp #(
  parameter int BLOCK_BYTES  = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_cmd,
  input  logic [ffba_pkg::SIZE_W-1:0]    in_req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]    in_free_addr,
  input  ffba_pkg::ffba_cmd_t            cmd,
  output ffba_pkg::ffba_sts_t            sts,
  output logic                           out_valid,
  output logic [ffba_pkg::ADDR_W-1:0]    out_result_addr,
  output logic [ffba_pkg::STAT_W-1:0]    out_status
);
  import ffba_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W   = CNT_W;
  localparam int ENT_W   = LEN_W + 2;
  localparam int REM_W   = $clog2(BLOCK_BYTES) + 1;
  localparam int BYTES_W = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);
  localparam int TOT_W   = SIZE_W + 1;
  localparam int CMP_W   = (BYTES_W > TOT_W) ? BYTES_W : TOT_W;

  localparam logic [ADDR_W-1:0] BB64  = ADDR_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] HDR64 = ADDR_W'(HEADER_BYTES);

  // heap registers
  logic [ADDR_W-1:0] heap_start_r, heap_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_start_r <= '0;
      heap_end_r   <= ADDR_W'(65536);
    end else if (cfg_we) begin
      if (cfg_index == CFG_HEAP_START) heap_start_r <= cfg_data;
      if (cfg_index == CFG_HEAP_END)   heap_end_r   <= cfg_data;
    end
  end

  // block map: {used, start, length}
  logic [ENT_W-1:0] mem [MAX_BLOCKS];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic               empty_r, empty_nxt;
  logic [ADDR_W:0]    limit_r, limit_nxt;
  logic [CNT_W-1:0]   nblocks_r, nblocks_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]  blk_r, blk_nxt;
  logic               cmd_r, cmd_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [ADDR_W-1:0]  target_r, target_nxt;
  logic               bad_r, bad_nxt;
  logic [LEN_W-1:0]   run_len_r, run_len_nxt;
  logic [BYTES_W-1:0] run_bytes_r, run_bytes_nxt;
  logic [CNT_W-1:0]   run_start_r, run_start_nxt;
  logic [ADDR_W-1:0]  run_addr_r, run_addr_nxt;
  logic [CNT_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [LEN_W-1:0]   wr_left_r, wr_left_nxt;
  logic [LEN_W-1:0]   wr_len_r, wr_len_nxt;
  logic               wr_set_r, wr_set_nxt;
  logic               wr_first_r, wr_first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [STAT_W-1:0]  out_st_r, out_st_nxt;

  logic              rd_used, rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [ADDR_W:0]   align_sum;
  logic [ADDR_W-1:0] align_add;
  logic [BYTES_W-1:0] bytes_inc;

  assign rd_used   = rd_data_r[ENT_W-1];
  assign rd_start  = rd_data_r[ENT_W-2];
  assign rd_len    = rd_data_r[LEN_W-1:0];
  assign align_add = (rem_r == '0) ? '0 : (BB64 - ADDR_W'(rem_r));
  assign align_sum = {1'b0, heap_start_r} + {1'b0, align_add};
  assign bytes_inc = run_bytes_r + BYTES_W'(BLOCK_BYTES);

  assign sts.clear_done = (idx_r == CNT_W'(MAX_BLOCKS - 1));
  assign sts.scan_end   = (idx_r == nblocks_r);
  assign sts.fit        = !rd_used && (CMP_W'(bytes_inc) >= CMP_W'(total_r));
  assign sts.match      = (blk_r == target_r);
  assign sts.start_bit  = rd_start;
  assign sts.wr_last    = (wr_left_r == LEN_W'(1));
  assign sts.bad_addr   = bad_r;

  always_comb begin
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    empty_nxt     = empty_r;
    limit_nxt     = limit_r;
    nblocks_nxt   = nblocks_r;
    idx_nxt       = idx_r;
    blk_nxt       = blk_r;
    cmd_nxt       = cmd_r;
    total_nxt     = total_r;
    target_nxt    = target_r;
    bad_nxt       = bad_r;
    run_len_nxt   = run_len_r;
    run_bytes_nxt = run_bytes_r;
    run_start_nxt = run_start_r;
    run_addr_nxt  = run_addr_r;
    wr_idx_nxt    = wr_idx_r;
    wr_left_nxt   = wr_left_r;
    wr_len_nxt    = wr_len_r;
    wr_set_nxt    = wr_set_r;
    wr_first_nxt  = wr_first_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IDX_W-1:0];
    mem_wdata     = '0;

    // start offset within its block
    if (cmd.setup_init) begin
      rem_nxt = REM_W'(heap_start_r % BB64);
    end
    if (cmd.align) begin
      base_nxt    = align_sum[ADDR_W] ? '0 : align_sum[ADDR_W-1:0];
      empty_nxt   = align_sum[ADDR_W] || (heap_end_r <= align_sum[ADDR_W-1:0]);
      limit_nxt   = align_sum + {1'b0, BB64};
      nblocks_nxt = '0;
      idx_nxt     = '0;
    end
    // clear one entry a cycle, count blocks that end within the heap
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r[IDX_W-1:0];
      mem_wdata = '0;
      if (!empty_r && (limit_r <= {1'b0, heap_end_r})) nblocks_nxt = idx_r + CNT_W'(1);
      limit_nxt = limit_r + {1'b0, BB64};
      idx_nxt   = idx_r + CNT_W'(1);
    end
    if (cmd.req_init) begin
      cmd_nxt       = in_cmd;
      total_nxt     = TOT_W'(in_req_size) + TOT_W'(HEADER_BYTES);
      target_nxt    = in_free_addr - HDR64;
      bad_nxt       = (in_free_addr == '0) || (in_free_addr < HDR64);
      idx_nxt       = '0;
      blk_nxt       = base_r;
      run_len_nxt   = '0;
      run_bytes_nxt = '0;
    end
    if (cmd.a_eval) begin
      if (rd_used) begin
        run_len_nxt   = '0;
        run_bytes_nxt = '0;
      end else begin
        if (run_len_r == '0) begin
          run_start_nxt = idx_r;
          run_addr_nxt  = blk_r;
        end
        run_len_nxt   = run_len_r + LEN_W'(1);
        run_bytes_nxt = bytes_inc;
      end
      idx_nxt = idx_r + CNT_W'(1);
      blk_nxt = blk_r + BB64;
    end
    if (cmd.a_wr_init) begin
      wr_idx_nxt   = run_start_nxt;
      wr_left_nxt  = run_len_nxt;
      wr_len_nxt   = run_len_nxt;
      wr_set_nxt   = 1'b1;
      wr_first_nxt = 1'b1;
    end
    if (cmd.f_step) begin
      idx_nxt = idx_r + CNT_W'(1);
      blk_nxt = blk_r + BB64;
    end
    if (cmd.f_wr_init) begin
      wr_idx_nxt   = idx_r;
      wr_left_nxt  = rd_len;
      wr_len_nxt   = rd_len;
      wr_set_nxt   = 1'b0;
      wr_first_nxt = 1'b1;
    end
    if (cmd.wr_step) begin
      mem_we       = 1'b1;
      mem_waddr    = wr_idx_r[IDX_W-1:0];
      mem_wdata    = {wr_set_r, wr_set_r & wr_first_r, wr_len_r};
      wr_idx_nxt   = wr_idx_r + CNT_W'(1);
      wr_left_nxt  = wr_left_r - LEN_W'(1);
      wr_first_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = cmd.post;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;
    if (cmd.post) begin
      out_st_nxt   = cmd.post_st;
      out_addr_nxt = ((cmd.post_st == STAT_OK) && (cmd_r == CMD_ALLOC)) ?
                     (run_addr_r + HDR64) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    base_r      <= base_nxt;
    empty_r     <= empty_nxt;
    limit_r     <= limit_nxt;
    nblocks_r   <= nblocks_nxt;
    idx_r       <= idx_nxt;
    blk_r       <= blk_nxt;
    cmd_r       <= cmd_nxt;
    total_r     <= total_nxt;
    target_r    <= target_nxt;
    bad_r       <= bad_nxt;
    run_len_r   <= run_len_nxt;
    run_bytes_r <= run_bytes_nxt;
    run_start_r <= run_start_nxt;
    run_addr_r  <= run_addr_nxt;
    wr_idx_r    <= wr_idx_nxt;
    wr_left_r   <= wr_left_nxt;
    wr_len_r    <= wr_len_nxt;
    wr_set_r    <= wr_set_nxt;
    wr_first_r  <= wr_first_nxt;
    out_addr_r  <= out_addr_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_st_r;

endmodule

FILE: src/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Block-granular first-fit heap allocator with implicit coalescing.
// ----------------------------------------------------------------------------
// Usage: pulse start with busy low to issue one request (in_cmd 0 allocate,
// 1 free). Exactly one result comes back on out_result_addr/out_status
// unless a heap register write restarts setup first; it is valid for the
// single cycle out_valid is high; there is no back-pressure, so capture it
// then. busy stays high from the accepting edge until the cycle the result
// is posted. An allocate that fits reads the block map memory and evaluates
// each block scanned, up to and including the last block of the fitting run,
// then writes the run's blocks; a miss scans every block. A free steps block
// by block up to and including the matching one, reads the map entry, then
// writes each released block. Reset and every write of heap_start or
// heap_end start a setup (alignment, then a clearing pass over the block map
// memory, one entry per cycle); busy is high meanwhile.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int BLOCK_BYTES  = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [ffba_pkg::SIZE_W-1:0]    in_req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]    in_free_addr,
  // result channel
  output logic                           out_valid,
  output logic [ffba_pkg::ADDR_W-1:0]    out_result_addr,
  output logic [ffba_pkg::STAT_W-1:0]    out_status,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;
  logic      cfg_we;
  logic      req_go;

  // writes are always taken; only known indexes touch the heap
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready &&
                     ((cfg_index == CFG_HEAP_START) || (cfg_index == CFG_HEAP_END));
  assign req_go    = start && !busy;

  ffba_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (req_go),
    .in_cmd (in_cmd),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  ffba_dp #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cmd          (in_cmd),
    .in_req_size     (in_req_size),
    .in_free_addr    (in_free_addr),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  // a result is a single-cycle strobe per request
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // an accepted request keeps the block busy
  a_busy_after_go: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // a result only ends busy work
  a_post_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("result posted while idle");

  // failed results carry a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_result_addr == '0))
    else $error("nonzero address on failure");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator: directed and random
// allocate/free requests against a block-map predictor, over several heap
// settings including empty and capped heaps.
// ----------------------------------------------------------------------------
module tb_top;
  import ffba_pkg::*;

  localparam int  BLK      = BLOCK_BYTES_DEF;
  localparam int  NMAX     = MAX_BLOCKS_DEF;
  localparam int  HDR      = HEADER_BYTES_DEF;
  localparam int  CYC_LIMIT = 6000000;
  localparam int  TAIL_CYC = 200;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } alloc_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_cmd;
  logic [SIZE_W-1:0]    in_req_size;
  logic [ADDR_W-1:0]    in_free_addr;
  logic                 out_valid;
  logic [ADDR_W-1:0]    out_result_addr;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  // predictor copy of heap registers and block map
  logic [ADDR_W-1:0] heap_lo;
  logic [ADDR_W-1:0] heap_hi;
  logic [ADDR_W-1:0] heap_base;
  int                heap_blocks;
  bit                blk_used [NMAX];
  bit                blk_head [NMAX];
  int                blk_len  [NMAX];

  alloc_result_t     pending_results[$];
  logic [ADDR_W-1:0] live_addrs[$];
  int                err_cnt;
  int                gap_pct;
  longint            cyc_cnt;

  first_fit_block_allocator dut (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Rebuild heap geometry; every block free again.
  function automatic void heap_rebuild();
    logic [ADDR_W-1:0] rem;
    logic [ADDR_W-1:0] pad;
    logic [ADDR_W-1:0] cnt;
    for (int i = 0; i < NMAX; i++) begin
      blk_used[i] = 0;
      blk_head[i] = 0;
      blk_len[i]  = 0;
    end
    heap_base   = '0;
    heap_blocks = 0;
    rem = heap_lo % BLK;
    if (rem != 0) begin
      pad = BLK - rem;
      if (heap_lo > ~64'd0 - pad) return; // alignment wraps: empty heap
      heap_base = heap_lo + pad;
    end else begin
      heap_base = heap_lo;
    end
    if (heap_hi <= heap_base) return;
    cnt = (heap_hi - heap_base) / BLK;
    heap_blocks = (cnt > NMAX) ? NMAX : int'(cnt);
  endfunction

  // First-fit over maximal free runs.
  function automatic alloc_result_t predict_alloc(logic [SIZE_W-1:0] sz);
    alloc_result_t r;
    logic [ADDR_W-1:0] need;
    int i;
    int j;
    r.addr = '0;
    r.st   = STAT_NOFIT;
    need = ({32'd0, sz} + HDR + BLK - 1) / BLK;
    if (need == 0) need = 1;
    i = 0;
    while (i < heap_blocks) begin
      if (blk_used[i]) begin
        i++;
        continue;
      end
      j = i;
      while (j < heap_blocks && !blk_used[j]) j++;
      if (64'(j - i) >= need) begin
        for (int k = 0; k < int'(need); k++) blk_used[i + k] = 1;
        blk_head[i] = 1;
        blk_len[i]  = int'(need);
        r.addr = heap_base + 64'(i) * BLK + HDR;
        r.st   = STAT_OK;
        return r;
      end
      i = j;
    end
    return r;
  endfunction

  function automatic status_t predict_free(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] p;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] idx;
    if (a == 0 || a < HDR) return STAT_NOTALLOC;
    p = a - HDR;
    if (p < heap_base) return STAT_NOTALLOC;
    off = p - heap_base;
    if (off % BLK != 0) return STAT_NOTALLOC;
    idx = off / BLK;
    if (idx >= heap_blocks || !blk_head[idx]) return STAT_NOTALLOC;
    for (int k = 0; k < blk_len[idx] && idx + k < heap_blocks; k++)
      blk_used[idx + k] = 0;
    blk_head[idx] = 0;
    return STAT_OK;
  endfunction

  // One request; start stays high after acceptance unless a gap follows.
  task automatic send_request(logic cmd, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
    alloc_result_t r;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_req_size  <= sz;
    in_free_addr <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_ALLOC) begin
      r = predict_alloc(sz);
      if (r.st == STAT_OK) live_addrs.push_back(r.addr);
    end else begin
      r.addr = '0;
      r.st   = predict_free(a);
      if (r.st == STAT_OK)
        foreach (live_addrs[i])
          if (live_addrs[i] == a) begin
            live_addrs.delete(i);
            break;
          end
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only with nothing in flight.
  task automatic write_heap_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HEAP_START) heap_lo = val;
    else heap_hi = val;
    live_addrs.delete();
    heap_rebuild();
  endtask

  task automatic set_heap(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    write_heap_reg(CFG_HEAP_START, lo);
    write_heap_reg(CFG_HEAP_END, hi);
  endtask

  // Extremes of size and address, whole-heap use, bad frees, coalescing.
  task automatic test_directed();
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] a1;
    gap_pct = 11;
    send_request(CMD_ALLOC, 32'd0, '0);               // zero-sized request
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, '1);       // far too large
    send_request(CMD_FREE, '1, 64'd0);                // null free
    send_request(CMD_FREE, '0, 64'd15);               // below header
    send_request(CMD_FREE, '0, 64'd16 + 64'd8);       // off the block grid
    send_request(CMD_FREE, '0, 64'(NMAX) * BLK + HDR); // past heap end
    send_request(CMD_FREE, '0, '1);
    a0 = live_addrs[0];
    send_request(CMD_FREE, '0, a0);
    send_request(CMD_FREE, '0, a0);                   // double free
    // whole heap in one allocation, then nothing fits
    send_request(CMD_ALLOC, 32'(NMAX * BLK - HDR), '0);
    send_request(CMD_ALLOC, 32'd1, '0);
    send_request(CMD_FREE, '0, live_addrs[0]);
    // neighbours freed merge into one run
    send_request(CMD_ALLOC, 32'd100, '0);
    send_request(CMD_ALLOC, 32'd48, '0);
    send_request(CMD_ALLOC, 32'(NMAX * BLK - 4 * BLK), '0);
    a0 = live_addrs[0];
    a1 = live_addrs[1];
    send_request(CMD_FREE, '0, a1);
    send_request(CMD_FREE, '0, a0);
    send_request(CMD_ALLOC, 32'(3 * BLK - HDR), '0);  // exactly the merged run
    send_request(CMD_ALLOC, 32'd0, '0);               // heap now full: nothing fits
    wait_drained();                                    // sender holds off until all back
  endtask

  // Empty heaps and alignment at the top of the address space.
  task automatic test_heap_edges();
    gap_pct = 11;
    set_heap('1, '1);                                  // alignment overflows
    send_request(CMD_ALLOC, 32'd0, '0);
    send_request(CMD_FREE, '0, 64'd16);
    set_heap('0, '0);                                  // end not above start
    send_request(CMD_ALLOC, 32'd0, '0);
    set_heap(64'hFFFF_FFFF_FFFF_FFC1, '1);            // zero blocks after align
    send_request(CMD_ALLOC, 32'd0, '0);
    set_heap(64'hFFFF_FFFF_FFFF_F001, '1);            // 62 blocks near the top
    send_request(CMD_ALLOC, 32'd5000, '0);
    send_request(CMD_ALLOC, 32'd0, '0);
    send_request(CMD_FREE, '0, live_addrs[0]);
    send_request(CMD_FREE, '0, '1);
    set_heap('0, '1);                                  // capped at the block limit
    send_request(CMD_ALLOC, 32'(NMAX * BLK - HDR), '0);
    send_request(CMD_ALLOC, 32'd0, '0);
  endtask

  // Mostly well-formed alloc/free traffic with random content, some noise.
  task automatic test_random(int n_req, int pct);
    int pick;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    gap_pct = pct;
    for (int n = 0; n < n_req; n++) begin
      pick = $urandom_range(99);
      if (pick < 50 || (pick < 85 && live_addrs.size() == 0)) begin
        case ($urandom_range(19))
          0:       sz = $urandom;
          1, 2:    sz = $urandom_range(20000);
          default: sz = $urandom_range(400);
        endcase
        send_request(CMD_ALLOC, sz, {$urandom, $urandom});
      end else if (pick < 85) begin
        a = live_addrs[$urandom_range(live_addrs.size() - 1)];
        send_request(CMD_FREE, $urandom, a);
      end else begin
        case ($urandom_range(2))
          0:       a = {$urandom, $urandom};
          1:       a = heap_base + HDR + 64'($urandom_range(NMAX + 4)) * BLK;
          default: a = heap_base + 64'($urandom_range(4 * NMAX * BLK));
        endcase
        send_request(CMD_FREE, $urandom, a);
      end
    end
  endtask

  // Result check against the oldest pending expectation.
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: addr %h status %0d", out_result_addr, out_status);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_result_addr !== e.addr) begin
          $error("result_addr: expected %h, got %h", e.addr, out_result_addr);
          err_cnt++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("first_fit_block_allocator verification failed");
      $finish;
    end
  end

  initial begin
    cyc_cnt      = 0;
    err_cnt      = 0;
    gap_pct      = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_ALLOC;
    in_req_size  = '0;
    in_free_addr = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_HEAP_START;
    cfg_data     = '0;
    heap_lo      = '0;
    heap_hi      = 64'd65536;
    heap_rebuild();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_heap_edges();
    // unaligned start, 299 blocks; sender rarely idle
    set_heap(64'h1005, 64'h1005 + 300 * BLK);
    test_random(190, 11);
    // small heap, sender mostly idle
    set_heap(64'h3F, 64'h3F + 40 * BLK + 10);
    test_random(190, 88);
    // random base, block-limited heap, back-to-back requests
    set_heap({$urandom, $urandom} & 64'h0FFF_FFFF_FFFF_FFFF, '1);
    test_random(190, 0);

    wait_drained();
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end

endmodule

FILE: first_fit_block_allocator.f
src/ffba_pkg.sv
src/ffba_ctrl.sv
src/ffba_dp.sv
src/first_fit_block_allocator.sv
test/tb_top.sv
